/* rtl/core/adlc_pkg.sv */
// Shared types and constants for the access decision cache.
// Depends on nothing; used by adlc_cell and access_decision_cache_lru_ttl.
`default_nettype none

package adlc_pkg;

	// default number of cells in the chain
	localparam int ADLC_ENTRIES = 64;

	// operation codes of an input word
	localparam logic [2:0] OP_LOOKUP = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_INVAL  = 3'd2;
	localparam logic [2:0] OP_FLUSH  = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	// configuration register indexes
	localparam logic [0:0] REG_ENTRY_LIMIT = 1'd0;
	localparam logic [0:0] REG_LIFETIME    = 1'd1;

	// reset values of the registers
	localparam logic [6:0]  LIMIT_RESET    = 7'd64;
	localparam logic [31:0] LIFETIME_RESET = 32'd100;

	typedef struct packed {
		logic [31:0] user;
		logic [31:0] group;
		logic [31:0] node;
		logic [7:0]  kind;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [7:0]  decision;
		logic [63:0] expiry;
	} entry_t;

	// what a cell loads this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PREV,
		CELL_NEXT
	} cell_op_t;

	typedef struct packed {
		logic     capture;
		cell_op_t op;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SWEEP
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/access_decision_cache_lru_ttl.sv */
// Access decision cache with LRU replacement and expiry, top level.
// Depends on adlc_pkg and adlc_cell (one per entry, chained by recency).
//
//  port group   | direction | handshake           | contents
//  -------------+-----------+---------------------+-----------------------------------
//  cfg_*        | in        | cfg_write           | entry_limit (0), lifetime_ticks (1)
//  input word   | in        | in_valid / in_ready | op, user_id, group_id, file_node,
//               |           |                     | access_kind, decision_in
//  result word  | out       | out_valid/out_ready | hit, decision_out, live_count,
//               |           |                     | hit_total, miss_total
//
// Cell 0 is the most recent entry; entries below live_count are valid.
// Lookup, insert, flush and tick pass an accept step (match flags captured
// in every cell) and an apply step (chain shifts, result registered).
// Invalidate passes accept, apply and a sweep in which the chain closes up
// one dropped cell per cycle until no dropped cell is left.
// No clearing pass after reset. A full result register stalls the apply step;
// the next word is accepted while a result waits.
`default_nettype none

module access_decision_cache_lru_ttl import adlc_pkg::*; #(
	parameter int ENTRIES = ADLC_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] user_id,
	input  wire logic [31:0] group_id,
	input  wire logic [31:0] file_node,
	input  wire logic [7:0]  access_kind,
	input  wire logic [7:0]  decision_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic [7:0]       decision_out,
	output logic [6:0]       live_count,
	output logic [31:0]      hit_total,
	output logic [31:0]      miss_total
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int LW = (CW > 7) ? CW : 7;

	state_t state_q, state_d;

	// registers
	logic [CW-1:0] count_q, count_next;
	logic [63:0]   time_q;
	logic [31:0]   hit_cnt_q, miss_cnt_q, hit_cnt_next, miss_cnt_next;
	logic [6:0]    limit_q;
	logic [31:0]   life_q;
	logic [2:0]    op_s1;
	key_t          key_s1;
	logic [7:0]    dec_s1;

	// result register
	logic          out_valid_q;
	logic          hit_q;
	logic [7:0]    dec_out_q;
	logic [6:0]    live_q;
	logic [31:0]   hit_tot_q, miss_tot_q;

	// chain signals
	key_t                 cmp_key;
	entry_t               cell_entry [ENTRIES];
	cell_ctrl_t           cell_ctrl  [ENTRIES];
	logic [ENTRIES-1:0]   cell_valid;
	logic [ENTRIES-1:0]   key_v, live_v, node_v;
	logic [ENTRIES-1:0]   sel, sfx, pfx;
	entry_t               head, head_sel;

	// control
	logic        can_load, capture, apply_fire, sweep_step, sweep_done, load_out;
	logic        is_lookup, is_insert, any_live, any_key, any_node;
	logic        do_promote, do_push, hit_n;
	logic [63:0] expiry_new;
	logic [LW-1:0] lim_w, lim_eff, count_w, keep;
	logic [CW-1:0] count_ins;

	assign cmp_key = '{user: user_id, group: group_id, node: file_node, kind: access_kind};

	// cell chain
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		entry_t prev_e, next_e;
		logic   next_n;

		assign cell_valid[g] = (CW'(g) < count_q);
		assign sfx[g] = |sel[ENTRIES-1:g];
		assign pfx[g] = |node_v[g:0];

		if (g == 0) begin : g_first
			assign prev_e = head;
		end else begin : g_mid_prev
			assign prev_e = cell_entry[g-1];
		end

		if (g == ENTRIES - 1) begin : g_last
			assign next_e = cell_entry[g];
			assign next_n = 1'b0;
		end else begin : g_mid_next
			assign next_e = cell_entry[g+1];
			assign next_n = node_v[g+1];
		end

		// per-cell move: promote shifts the cells from cell 0 to the hit, push shifts all,
		// sweep closes up the cells from the first dropped cell to the end of the chain
		always_comb begin
			cell_ctrl[g].capture = capture;
			cell_ctrl[g].op      = CELL_HOLD;
			if (apply_fire && do_push) begin
				cell_ctrl[g].op = CELL_PREV;
			end else if (apply_fire && do_promote && sfx[g]) begin
				cell_ctrl[g].op = CELL_PREV;
			end else if (sweep_step && pfx[g]) begin
				cell_ctrl[g].op = CELL_NEXT;
			end
		end

		adlc_cell u_cell (
			.clk           (clk),
			.valid         (cell_valid[g]),
			.ctrl          (cell_ctrl[g]),
			.cmp_key       (cmp_key),
			.now           (time_q),
			.prev_entry    (prev_e),
			.next_entry    (next_e),
			.next_node_hit (next_n),
			.entry         (cell_entry[g]),
			.key_hit       (key_v[g]),
			.live_hit      (live_v[g]),
			.node_hit      (node_v[g])
		);
	end

	// decode of the captured word
	assign is_lookup  = (op_s1 == OP_LOOKUP);
	assign is_insert  = (op_s1 == OP_INSERT);
	assign any_live   = |live_v;
	assign any_key    = |key_v;
	assign any_node   = |node_v;
	assign sel        = is_lookup ? live_v : key_v;
	assign do_promote = (is_lookup && any_live) || (is_insert && any_key);
	assign do_push    = is_insert && !any_key;
	assign expiry_new = time_q + {32'd0, life_q};

	// selected entry, one-hot and-or
	always_comb begin
		head_sel = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (live_v[i]) begin
				head_sel = head_sel | cell_entry[i];
			end
		end
	end

	assign head = is_lookup ? head_sel
		: '{key: key_s1, decision: dec_s1, expiry: expiry_new};

	// limit clamp and count after a push
	assign lim_w   = LW'(limit_q);
	assign lim_eff = (lim_w == '0) ? LW'(1)
		: ((lim_w > LW'(ENTRIES)) ? LW'(ENTRIES) : lim_w);
	assign count_w   = LW'(count_q);
	assign keep      = (count_w >= lim_eff) ? (lim_eff - LW'(1)) : count_w;
	assign count_ins = CW'(keep + LW'(1));

	// next count and counters
	assign hit_n = apply_fire && is_lookup && any_live;

	always_comb begin
		count_next = count_q;
		if (apply_fire && do_push) begin
			count_next = count_ins;
		end else if (apply_fire && (op_s1 == OP_FLUSH)) begin
			count_next = '0;
		end else if (sweep_step) begin
			count_next = count_q - CW'(1);
		end
	end

	assign hit_cnt_next  = hit_cnt_q + {31'd0, hit_n};
	assign miss_cnt_next = miss_cnt_q + {31'd0, apply_fire && is_lookup && !any_live};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (op_s1 == OP_INVAL) state_d = ST_SWEEP;
				else if (can_load) state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (!any_node && can_load) state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		in_ready   = 1'b0;
		capture    = 1'b0;
		apply_fire = 1'b0;
		sweep_step = 1'b0;
		sweep_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				capture  = in_valid;
			end
			ST_APPLY: begin
				apply_fire = (op_s1 != OP_INVAL) && can_load;
			end
			ST_SWEEP: begin
				sweep_step = any_node;
				sweep_done = !any_node && can_load;
			end
		endcase
	end

	assign load_out = apply_fire || sweep_done;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			time_q      <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			limit_q     <= LIMIT_RESET;
			life_q      <= LIFETIME_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_next;
			hit_cnt_q  <= hit_cnt_next;
			miss_cnt_q <= miss_cnt_next;
			if (apply_fire && (op_s1 == OP_TICK)) begin
				time_q <= time_q + 64'd1;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_ENTRY_LIMIT: limit_q <= cfg_data[6:0];
					REG_LIFETIME:    life_q  <= cfg_data;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// captured word and result payload
	always_ff @(posedge clk) begin
		if (capture) begin
			op_s1  <= op;
			key_s1 <= cmp_key;
			dec_s1 <= decision_in;
		end
		if (load_out) begin
			hit_q      <= hit_n;
			dec_out_q  <= hit_n ? head_sel.decision : 8'd0;
			live_q     <= 7'(count_next);
			hit_tot_q  <= hit_cnt_next;
			miss_tot_q <= miss_cnt_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign decision_out = dec_out_q;
	assign live_count   = live_q;
	assign hit_total    = hit_tot_q;
	assign miss_total   = miss_tot_q;

endmodule

`default_nettype wire

/* rtl/core/adlc_cell.sv */
// One cell of the recency chain: holds one entry and its match flags.
// Depends on adlc_pkg (key_t, entry_t, cell_ctrl_t).
`default_nettype none

module adlc_cell import adlc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        valid,
	input  wire cell_ctrl_t  ctrl,
	input  wire key_t        cmp_key,
	input  wire logic [63:0] now,
	input  wire entry_t      prev_entry,
	input  wire entry_t      next_entry,
	input  wire logic        next_node_hit,
	output entry_t           entry,
	output logic             key_hit,
	output logic             live_hit,
	output logic             node_hit
);

	entry_t entry_q;
	logic   key_hit_q;
	logic   live_hit_q;
	logic   node_hit_q;
	logic   key_eq;
	logic   unexpired;

	// compare against the incoming word's key
	assign key_eq    = valid && (entry_q.key == cmp_key);
	assign unexpired = now < entry_q.expiry;

	// match flags are taken when a word is accepted; entries move with the chain
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			key_hit_q  <= key_eq;
			live_hit_q <= key_eq && unexpired;
			node_hit_q <= valid && (entry_q.key.node == cmp_key.node);
		end
		unique case (ctrl.op)
			CELL_HOLD: ;
			CELL_PREV: entry_q <= prev_entry;
			CELL_NEXT: begin
				entry_q    <= next_entry;
				node_hit_q <= next_node_hit;
			end
		endcase
	end

	assign entry    = entry_q;
	assign key_hit  = key_hit_q;
	assign live_hit = live_hit_q;
	assign node_hit = node_hit_q;

endmodule

`default_nettype wire

/* verif/adlc_result_checker.sv */
// Result checker for the access decision cache: watches the register, input and
// result ports, predicts each result word and compares it field by field.
// Depends on adlc_pkg for the key type, operation codes and register indexes.
`default_nettype none

module adlc_result_checker import adlc_pkg::*; #(
	parameter int ENTRIES = ADLC_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] user_id,
	input  wire logic [31:0] group_id,
	input  wire logic [31:0] file_node,
	input  wire logic [7:0]  access_kind,
	input  wire logic [7:0]  decision_in,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        hit,
	input  wire logic [7:0]  decision_out,
	input  wire logic [6:0]  live_count,
	input  wire logic [31:0] hit_total,
	input  wire logic [31:0] miss_total,
	output int               mismatches,
	output int               outstanding,
	output int               words_checked,
	output int               hits_checked
);

	typedef struct packed {
		logic        hit;
		logic [7:0]  decision;
		logic [6:0]  live;
		logic [31:0] hits;
		logic [31:0] misses;
	} reply_t;

	// predicted cache contents; rank 0 is the most recent entry
	logic        held        [ENTRIES];
	key_t        held_key    [ENTRIES];
	logic [7:0]  held_dec    [ENTRIES];
	logic [63:0] held_expiry [ENTRIES];
	int          held_rank   [ENTRIES];
	int          held_count;
	logic [63:0] now_ticks;
	logic [31:0] hit_tally;
	logic [31:0] miss_tally;
	logic [6:0]  limit_reg;
	logic [31:0] life_reg;

	reply_t pending_replies[$];
	int     fail_tally;
	int     checked_tally;
	int     hit_seen_tally;

	function automatic int find_entry(key_t k);
		for (int i = 0; i < ENTRIES; i++)
			if (held[i] && held_key[i] == k)
				return i;
		return -1;
	endfunction

	// everything more recent than slot i moves back one rank
	function automatic void make_newest(int i);
		for (int j = 0; j < ENTRIES; j++)
			if (held[j] && j != i && held_rank[j] < held_rank[i])
				held_rank[j]++;
		held_rank[i] = 0;
	endfunction

	function automatic void drop_entry(int i);
		int r;
		r = held_rank[i];
		held[i] = 1'b0;
		for (int j = 0; j < ENTRIES; j++)
			if (held[j] && held_rank[j] > r)
				held_rank[j]--;
		if (held_count > 0)
			held_count--;
	endfunction

	function automatic void evict_stalest();
		int best;
		best = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (held[i] && (best < 0 || held_rank[i] > held_rank[best]))
				best = i;
		if (best >= 0)
			drop_entry(best);
		else
			held_count = 0;
	endfunction

	// apply one input word to the predicted cache and return its result
	function automatic reply_t predict_reply(logic [2:0] code, key_t k, logic [7:0] d);
		reply_t      r;
		int          i;
		int          cap;
		logic [63:0] expiry;
		r = '0;
		expiry = now_ticks + 64'(life_reg);
		case (code)
			OP_LOOKUP: begin
				i = find_entry(k);
				if (i >= 0 && now_ticks < held_expiry[i]) begin
					make_newest(i);
					r.hit = 1'b1;
					r.decision = held_dec[i];
					hit_tally++;
				end else begin
					miss_tally++;
				end
			end
			OP_INSERT: begin
				i = find_entry(k);
				if (i >= 0) begin
					// present key: overwrite in place, no eviction
					held_dec[i] = d;
					held_expiry[i] = expiry;
					make_newest(i);
				end else begin
					cap = (limit_reg == 0) ? 1 :
						(limit_reg > ENTRIES) ? ENTRIES : int'(limit_reg);
					while (held_count >= cap)
						evict_stalest();
					// lowest free slot takes the new entry
					i = -1;
					for (int j = 0; j < ENTRIES; j++)
						if (i < 0 && !held[j])
							i = j;
					if (i >= 0) begin
						for (int j = 0; j < ENTRIES; j++)
							if (held[j])
								held_rank[j]++;
						held[i] = 1'b1;
						held_key[i] = k;
						held_dec[i] = d;
						held_expiry[i] = expiry;
						held_rank[i] = 0;
						held_count++;
					end
				end
			end
			OP_INVAL: begin
				for (int j = 0; j < ENTRIES; j++)
					if (held[j] && held_key[j].node == k.node)
						drop_entry(j);
			end
			OP_FLUSH: begin
				for (int j = 0; j < ENTRIES; j++)
					held[j] = 1'b0;
				held_count = 0;
			end
			OP_TICK: begin
				now_ticks++;
			end
			default: begin
			end
		endcase
		r.live = 7'(held_count);
		r.hits = hit_tally;
		r.misses = miss_tally;
		return r;
	endfunction

	function automatic void reset_model();
		for (int j = 0; j < ENTRIES; j++)
			held[j] = 1'b0;
		held_count = 0;
		now_ticks = '0;
		hit_tally = '0;
		miss_tally = '0;
		limit_reg = LIMIT_RESET;
		life_reg = LIFETIME_RESET;
		pending_replies.delete();
		fail_tally = 0;
		checked_tally = 0;
		hit_seen_tally = 0;
	endfunction

	task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk) begin
		reply_t want;
		key_t   k;
		if (!arst_n) begin
			reset_model();
		end else begin
			// the user must make register writes only while the cache is idle; the cache does not enforce it
			if (cfg_write) begin
				if (cfg_index == REG_ENTRY_LIMIT)
					limit_reg = cfg_data[6:0];
				else if (cfg_index == REG_LIFETIME)
					life_reg = cfg_data;
			end
			// result word against the oldest prediction
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual hit %0d decision %0d",
						$time, hit, decision_out);
					fail_tally++;
				end else begin
					want = pending_replies.pop_front();
					report_field("hit", 64'(want.hit), 64'(hit));
					report_field("decision_out", 64'(want.decision), 64'(decision_out));
					report_field("live_count", 64'(want.live), 64'(live_count));
					report_field("hit_total", 64'(want.hits), 64'(hit_total));
					report_field("miss_total", 64'(want.misses), 64'(miss_total));
					checked_tally++;
					if (hit === 1'b1)
						hit_seen_tally++;
				end
			end
			// accepted input word: predict what it returns
			if (in_valid && in_ready) begin
				k = '{user: user_id, group: group_id, node: file_node, kind: access_kind};
				pending_replies.push_back(predict_reply(op, k, decision_in));
			end
		end
		mismatches <= fail_tally;
		outstanding <= pending_replies.size();
		words_checked <= checked_tally;
		hits_checked <= hit_seen_tally;
	end

endmodule

`default_nettype wire

/* verif/access_decision_cache_lru_ttl_test.sv */
// Testbench top for the access decision cache: drives directed and random words,
// register settings and back-pressure, and reports the verdict.
// Depends on adlc_pkg, access_decision_cache_lru_ttl and adlc_result_checker.
`default_nettype none

module access_decision_cache_lru_ttl_test;
	import adlc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 200;
	localparam int LONG_HOLD = 300;
	localparam int KEY_POOL = 96;
	localparam int SETTLE_CYCLES = 20;
	// codes the block ignores
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [0:0]  cfg_index = REG_ENTRY_LIMIT;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic [2:0]  op = OP_LOOKUP;
	logic [31:0] user_id = '0;
	logic [31:0] group_id = '0;
	logic [31:0] file_node = '0;
	logic [7:0]  access_kind = '0;
	logic [7:0]  decision_in = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        hit;
	logic [7:0]  decision_out;
	logic [6:0]  live_count;
	logic [31:0] hit_total;
	logic [31:0] miss_total;

	int mismatches;
	int outstanding;
	int words_checked;
	int hits_checked;

	int   sender_idle = 37;
	int   receiver_idle = 72;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   words_sent = 0;
	int   cycles = 0;

	// keys are built from small value pools so that lookups find inserted entries
	logic [31:0] users  [6];
	logic [31:0] groups [4];
	logic [31:0] nodes  [8];
	logic [7:0]  kinds  [4];
	key_t        key_pool [KEY_POOL];

	access_decision_cache_lru_ttl dut (.*);

	adlc_result_checker checker_i (.*);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_idle);
			end
		end
	end

	function automatic key_t random_key();
		return '{user: $urandom, group: $urandom, node: $urandom, kind: 8'($urandom)};
	endfunction

	task automatic refresh_pool(logic everything);
		if (everything) begin
			foreach (users[i]) users[i] = $urandom;
			foreach (groups[i]) groups[i] = $urandom;
			foreach (nodes[i]) nodes[i] = $urandom;
			foreach (kinds[i]) kinds[i] = 8'($urandom);
		end else begin
			users[$urandom_range(5)] = $urandom;
			groups[$urandom_range(3)] = $urandom;
			nodes[$urandom_range(7)] = $urandom;
			nodes[$urandom_range(7)] = $urandom;
			kinds[$urandom_range(3)] = 8'($urandom);
		end
		foreach (key_pool[i])
			key_pool[i] = '{user: users[$urandom_range(5)], group: groups[$urandom_range(3)],
				node: nodes[$urandom_range(7)], kind: kinds[$urandom_range(3)]};
	endtask

	// offer one word, leaving valid high after acceptance
	task automatic send_word(logic [2:0] code, key_t k, logic [7:0] d);
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		user_id <= k.user;
		group_id <= k.group;
		file_node <= k.node;
		access_kind <= k.kind;
		decision_in <= d;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// stop offering and wait for every outstanding result word
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_regs(logic [6:0] limit, logic [31:0] life);
		cfg_write <= 1'b1;
		cfg_index <= REG_ENTRY_LIMIT;
		cfg_data <= 32'(limit);
		@(posedge clk);
		cfg_index <= REG_LIFETIME;
		cfg_data <= life;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		key_t        key_hi;
		key_t        key_lo;
		key_t        key_kin;
		key_t        key_mate;
		key_t        key_short;
		key_t        k;
		logic [6:0]  limit_plan [PHASES];
		logic [31:0] life_plan [PHASES];
		logic [6:0]  limit;
		logic [31:0] life;
		logic [7:0]  d;
		int          pick;
		int          count;

		limit_plan = '{7'd8, 7'd0, 7'd127, 7'd64, 7'd3, 7'd32, 7'd1, 7'd64};
		life_plan = '{32'd12, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd30, 32'd20, 32'd1, 32'd25};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		refresh_pool(1'b1);

		// directed: extreme keys, overwrite, near-miss key, ignored codes,
		// invalidate of one and of several entries, flush
		key_hi = '{user: '1, group: '1, node: '1, kind: '1};
		key_lo = '0;
		key_kin = key_hi;
		key_kin.kind = 8'hFE;
		key_mate = '{user: 32'd1, group: 32'd0, node: 32'd0, kind: 8'd0};
		key_short = random_key();
		send_word(OP_LOOKUP, key_hi, 8'h00);
		send_word(OP_INSERT, key_hi, 8'hFF);
		send_word(OP_INSERT, key_lo, 8'h00);
		send_word(OP_LOOKUP, key_hi, 8'h00);
		send_word(OP_LOOKUP, key_lo, 8'hFF);
		send_word(OP_INSERT, key_hi, 8'h5A);
		send_word(OP_LOOKUP, key_hi, 8'h00);
		send_word(OP_LOOKUP, key_kin, 8'h00);
		for (int c = int'(OP_SPARE_LO); c <= int'(OP_SPARE_HI); c++)
			send_word(3'(c), random_key(), 8'($urandom));
		send_word(OP_TICK, key_lo, 8'h00);
		send_word(OP_INVAL, key_hi, 8'h00);
		send_word(OP_LOOKUP, key_hi, 8'h00);
		send_word(OP_INSERT, key_mate, 8'hA5);
		send_word(OP_INVAL, key_lo, 8'h00);
		send_word(OP_LOOKUP, key_mate, 8'h00);
		send_word(OP_INSERT, key_hi, 8'hC3);
		send_word(OP_FLUSH, key_lo, 8'h00);
		send_word(OP_LOOKUP, key_hi, 8'h00);

		// expiry: a lookup at the expiry tick misses
		drain();
		write_regs(LIMIT_RESET, 32'd2);
		send_word(OP_INSERT, key_short, 8'h7E);
		send_word(OP_LOOKUP, key_short, 8'h00);
		send_word(OP_TICK, key_lo, 8'h00);
		send_word(OP_TICK, key_lo, 8'h00);
		send_word(OP_LOOKUP, key_short, 8'h00);

		// random phases, each under its own limit and lifetime
		for (int p = 0; p < PHASES; p++) begin
			drain();
			limit = (p == 5) ? 7'($urandom_range(64, 1)) : limit_plan[p];
			life = (p == 5) ? 32'($urandom_range(40, 1)) : life_plan[p];
			write_regs(limit, life);
			refresh_pool(1'b0);
			if (p < 3) begin
				sender_idle = 37;
				receiver_idle = 72;
			end else if (p < 6) begin
				sender_idle = 72;
				receiver_idle = 37;
			end else begin
				sender_idle = 0;
				receiver_idle = 0;
			end
			// result side holds off while words keep coming
			if (p == 6)
				hold_req = 1'b1;
			count = 0;
			while (count < WORDS_PER_PHASE) begin
				pick = $urandom_range(99);
				k = key_pool[$urandom_range(KEY_POOL - 1)];
				d = 8'($urandom);
				if (pick < 44) begin
					if ($urandom_range(19) == 0)
						k = random_key();
					send_word(OP_LOOKUP, k, d);
				end else if (pick < 74) begin
					send_word(OP_INSERT, k, d);
				end else if (pick < 88) begin
					send_word(OP_TICK, k, d);
				end else if (pick < 95) begin
					if ($urandom_range(9) == 0)
						k.node = $urandom;
					send_word(OP_INVAL, k, d);
				end else if (pick < 96) begin
					send_word(OP_FLUSH, k, d);
				end else begin
					send_word(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), k, d);
					count--;
				end
				count++;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run: %0d words sent under %0d register settings, %0d results checked (%0d hits).",
			words_sent, PHASES + 2, words_checked, hits_checked);
		$display("Covered limit extremes, overwrite, expiry, invalidate, flush and a long stall.");
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/adlc_pkg.sv
rtl/core/adlc_cell.sv
rtl/core/access_decision_cache_lru_ttl.sv
verif/adlc_result_checker.sv
verif/access_decision_cache_lru_ttl_test.sv
